/* hw/rtl/gds_pkg.sv */
`timescale 1ns / 1ps

package gds_pkg;

  // Fixed field widths.
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned CONF_W   = 8;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_MIN   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [DIST_W-1:0] RADIUS_SQ_RST = 32'd41943;
  localparam logic [CONF_W-1:0] CONF_MIN_RST  = 8'd128;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACCEPT  = 2'd0,
    STATUS_LOWCONF = 2'd1,
    STATUS_DUP     = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the incoming request
    logic issue;   // read the next stored entry
    logic finish;  // decide, commit and load the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic low_conf;    // captured confidence does not exceed the threshold
    logic list_empty;  // no stored entries in this frame
    logic issue_last;  // the entry being read now is the last stored one
    logic pipe_busy;   // comparisons still in flight
    logic out_free;    // output register can take a result this cycle
  } stat_t;

endpackage

/* hw/rtl/gds_ctrl.sv */
`timescale 1ns / 1ps

module gds_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  gds_pkg::stat_t  stat,
  output gds_pkg::cmd_t   cmd
);

  gds_pkg::state_t state;
  gds_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      gds_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = gds_pkg::ST_START;
        end
      end
      gds_pkg::ST_START: begin
        if (stat.low_conf || stat.list_empty) begin
          state_next = gds_pkg::ST_FINISH;
        end else begin
          state_next = gds_pkg::ST_SCAN;
        end
      end
      gds_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) begin
          state_next = gds_pkg::ST_DRAIN;
        end
      end
      gds_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = gds_pkg::ST_FINISH;
        end
      end
      gds_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = gds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gds_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/gds_datapath.sv */
`timescale 1ns / 1ps

module gds_datapath #(
  parameter int unsigned MAX_KEPT = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gds_pkg::DIST_W-1:0]          cfg_data,
  input  logic                                frame_start,
  input  logic signed [gds_pkg::COORD_W-1:0]  cand_x,
  input  logic signed [gds_pkg::COORD_W-1:0]  cand_y,
  input  logic signed [gds_pkg::COORD_W-1:0]  cand_z,
  input  logic [gds_pkg::CONF_W-1:0]          confidence,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gds_pkg::STATUS_W-1:0]        status,
  output logic signed [gds_pkg::COORD_W-1:0]  out_x,
  output logic signed [gds_pkg::COORD_W-1:0]  out_y,
  output logic signed [gds_pkg::COORD_W-1:0]  out_z,
  output logic [gds_pkg::SLOT_W-1:0]          slot_index,
  input  gds_pkg::cmd_t                       cmd,
  output gds_pkg::stat_t                      stat
);

  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CW = $clog2(MAX_KEPT + 1);
  localparam int unsigned SQ_W  = 2 * gds_pkg::COORD_W;
  localparam int unsigned SUM_W = SQ_W + 1;

  // Configuration.
  logic [gds_pkg::DIST_W-1:0] radius_sq;
  logic [gds_pkg::CONF_W-1:0] confidence_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq      <= gds_pkg::RADIUS_SQ_RST;
      confidence_min <= gds_pkg::CONF_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gds_pkg::REG_RADIUS_SQ: radius_sq      <= cfg_data;
        gds_pkg::REG_CONF_MIN:  confidence_min <= cfg_data[gds_pkg::CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured candidate.
  logic signed [gds_pkg::COORD_W-1:0] cx;
  logic signed [gds_pkg::COORD_W-1:0] cy;
  logic signed [gds_pkg::COORD_W-1:0] cz;
  logic [gds_pkg::CONF_W-1:0]         cconf;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx    <= cand_x;
      cy    <= cand_y;
      cz    <= cand_z;
      cconf <= confidence;
    end
  end

  // Entry count and scan pointer.
  logic [CW-1:0] kept_count;
  logic [AW-1:0] rd_idx;
  logic          accept_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
    end else if (cmd.load && frame_start) begin
      kept_count <= '0;
    end else if (accept_now) begin
      kept_count <= kept_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      rd_idx <= '0;
    end else if (cmd.issue) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  // Stored positions.
  logic signed [gds_pkg::COORD_W-1:0] kept_x [MAX_KEPT];
  logic signed [gds_pkg::COORD_W-1:0] kept_y [MAX_KEPT];
  logic signed [gds_pkg::COORD_W-1:0] rd_x;
  logic signed [gds_pkg::COORD_W-1:0] rd_y;

  always_ff @(posedge clk) begin
    if (accept_now) begin
      kept_x[kept_count[AW-1:0]] <= cx;
      kept_y[kept_count[AW-1:0]] <= cy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_x <= kept_x[rd_idx];
      rd_y <= kept_y[rd_idx];
    end
  end

  // Compare pipeline: read, square, sum and compare.
  logic v1;
  logic v2;
  logic signed [gds_pkg::COORD_W:0] dx;
  logic signed [gds_pkg::COORD_W:0] dy;
  logic [gds_pkg::COORD_W-1:0]      ax;
  logic [gds_pkg::COORD_W-1:0]      ay;
  logic [SQ_W-1:0]                  sqx;
  logic [SQ_W-1:0]                  sqy;
  logic [SUM_W-1:0]                 dist_sum;
  logic                             dup;

  always_comb begin
    dx = {cx[gds_pkg::COORD_W-1], cx} - {rd_x[gds_pkg::COORD_W-1], rd_x};
    dy = {cy[gds_pkg::COORD_W-1], cy} - {rd_y[gds_pkg::COORD_W-1], rd_y};
    // The magnitude of a 16-bit difference always fits in 16 bits.
    ax = dx[gds_pkg::COORD_W] ? gds_pkg::COORD_W'(-dx) : dx[gds_pkg::COORD_W-1:0];
    ay = dy[gds_pkg::COORD_W] ? gds_pkg::COORD_W'(-dy) : dy[gds_pkg::COORD_W-1:0];
    dist_sum = SUM_W'(sqx) + SUM_W'(sqy);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      dup <= 1'b0;
    end else if (v2 && (dist_sum < SUM_W'(radius_sq))) begin
      dup <= 1'b1;
    end
  end

  // Decision.
  logic                      low_conf;
  logic                      full;
  gds_pkg::status_t          res_status;

  always_comb begin
    low_conf = (cconf <= confidence_min);
    full     = (kept_count == CW'(MAX_KEPT));
    if (low_conf) begin
      res_status = gds_pkg::STATUS_LOWCONF;
    end else if (dup) begin
      res_status = gds_pkg::STATUS_DUP;
    end else if (full) begin
      res_status = gds_pkg::STATUS_FULL;
    end else begin
      res_status = gds_pkg::STATUS_ACCEPT;
    end
    accept_now = cmd.finish && (res_status == gds_pkg::STATUS_ACCEPT);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= res_status;
      out_x      <= cx;
      out_y      <= cy;
      out_z      <= cz;
      slot_index <= (res_status == gds_pkg::STATUS_ACCEPT) ?
                    gds_pkg::SLOT_W'(kept_count) : '0;
    end
  end

  always_comb begin
    stat.low_conf   = low_conf;
    stat.list_empty = (kept_count == '0);
    stat.issue_last = ((CW'(rd_idx) + CW'(1)) == kept_count);
    stat.pipe_busy  = v1 || v2;
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

/* hw/rtl/greedy_distance_suppression_top.sv */
`timescale 1ns / 1ps

// Greedy distance suppression of object candidates.
// A candidate request enters on the input channel (in_valid / in_stall) with
// its position, confidence and a frame start flag. A set frame start flag
// empties the list of kept entries before that candidate is judged. One
// result request leaves on the output channel (out_valid / out_stall) for
// every candidate: accepted with its slot, low confidence, duplicate or
// dropped because the list is full. The user writes registers via cfg_we,
// cfg_index and cfg_data only while the block is idle; nothing enforces it.
// After a candidate is accepted the sequencer steps through START, SCAN,
// DRAIN and FINISH. SCAN reads the kept entries one after another through
// the single read port of the list memory, DRAIN waits for the compare
// pipeline to empty and FINISH commits once the output register is free; a
// candidate at or below the floor, or one meeting an empty list, goes from
// START to FINISH. The input stays stalled until the sequencer is idle again.
// A finished result waits in the output register, so the next candidate is
// taken and scanned while the receiver stalls; only its final commit waits
// for the register to free up. Reset empties the list, clears both channels
// and restores the default distance and confidence thresholds.
module greedy_distance_suppression_top #(
  parameter int unsigned MAX_KEPT = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gds_pkg::DIST_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                frame_start,
  input  logic signed [gds_pkg::COORD_W-1:0]  cand_x,
  input  logic signed [gds_pkg::COORD_W-1:0]  cand_y,
  input  logic signed [gds_pkg::COORD_W-1:0]  cand_z,
  input  logic [gds_pkg::CONF_W-1:0]          confidence,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gds_pkg::STATUS_W-1:0]        status,
  output logic signed [gds_pkg::COORD_W-1:0]  out_x,
  output logic signed [gds_pkg::COORD_W-1:0]  out_y,
  output logic signed [gds_pkg::COORD_W-1:0]  out_z,
  output logic [gds_pkg::SLOT_W-1:0]          slot_index
);

  // Commands and status between the sequencer and the datapath.
  gds_pkg::cmd_t  cmd;
  gds_pkg::stat_t stat;

  gds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  gds_datapath #(
    .MAX_KEPT (MAX_KEPT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .frame_start (frame_start),
    .cand_x      (cand_x),
    .cand_y      (cand_y),
    .cand_z      (cand_z),
    .confidence  (confidence),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .slot_index  (slot_index),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

/* test/greedy_distance_suppression_top_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the greedy distance suppression block.
module greedy_distance_suppression_top_tb;

  // The block is built with its default list depth, so the local predictor
  // uses the same depth.
  localparam int unsigned KEEP_DEPTH    = 64;
  // Length of the long output hold that backs the block up into its input.
  localparam int unsigned HOLD_CYCLES   = 400;
  // Quiet cycles after the last result before a register write. Every
  // request produces exactly one result, so a short pause is enough.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Even if every request scanned a full list, the whole run, with the worst
  // gaps and stalls, would stay well below this.
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // One candidate request as the bench queues it.
  typedef struct {
    logic                               fs;
    logic signed [gds_pkg::COORD_W-1:0] x;
    logic signed [gds_pkg::COORD_W-1:0] y;
    logic signed [gds_pkg::COORD_W-1:0] z;
    logic [gds_pkg::CONF_W-1:0]         conf;
  } cand_t;

  // One expected result request.
  typedef struct {
    gds_pkg::status_t                   status;
    logic signed [gds_pkg::COORD_W-1:0] x;
    logic signed [gds_pkg::COORD_W-1:0] y;
    logic signed [gds_pkg::COORD_W-1:0] z;
    logic [gds_pkg::SLOT_W-1:0]         slot;
  } verdict_t;

  // Every input of the block starts at a known value; reset is high from
  // time zero.
  logic                               clk         = 1'b0;
  logic                               rst         = 1'b1;
  logic                               cfg_we      = 1'b0;
  logic [gds_pkg::CFG_IDX_W-1:0]      cfg_index   = '0;
  logic [gds_pkg::DIST_W-1:0]         cfg_data    = '0;
  logic                               in_valid    = 1'b0;
  logic                               frame_start = 1'b0;
  logic signed [gds_pkg::COORD_W-1:0] cand_x      = '0;
  logic signed [gds_pkg::COORD_W-1:0] cand_y      = '0;
  logic signed [gds_pkg::COORD_W-1:0] cand_z      = '0;
  logic [gds_pkg::CONF_W-1:0]         confidence  = '0;
  logic                               out_stall   = 1'b0;

  logic                               in_stall;
  logic                               out_valid;
  logic [gds_pkg::STATUS_W-1:0]       status;
  logic signed [gds_pkg::COORD_W-1:0] out_x;
  logic signed [gds_pkg::COORD_W-1:0] out_y;
  logic signed [gds_pkg::COORD_W-1:0] out_z;
  logic [gds_pkg::SLOT_W-1:0]         slot_index;

  // Requests waiting to be offered, and results the block still owes us.
  cand_t    cand_backlog [$];
  verdict_t verdicts_due [$];
  cand_t    on_wire;
  verdict_t want;

  // Predictor state: the kept positions of the current frame and the two
  // thresholds as last written.
  logic signed [gds_pkg::COORD_W-1:0] roster_x [KEEP_DEPTH];
  logic signed [gds_pkg::COORD_W-1:0] roster_y [KEEP_DEPTH];
  int                                 roster_len = 0;
  logic [gds_pkg::DIST_W-1:0]         clear_sq   = gds_pkg::RADIUS_SQ_RST;
  logic [gds_pkg::CONF_W-1:0]         conf_floor = gds_pkg::CONF_MIN_RST;
  int                                 by_status [4];

  int n_offered   = 0;
  int n_taken     = 0;
  int n_checked   = 0;
  int n_frames    = 0;
  int n_writes    = 0;
  int errors      = 0;
  int cycle_count = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  bit send_idle   = 1'b1;
  bit recv_idle   = 1'b1;
  bit hold_req    = 1'b0;

  greedy_distance_suppression_top #(
    .MAX_KEPT (KEEP_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_start (frame_start),
    .cand_x      (cand_x),
    .cand_y      (cand_y),
    .cand_z      (cand_z),
    .confidence  (confidence),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .slot_index  (slot_index)
  );

  always #1 clk = ~clk;

  // Works out the result of one accepted candidate and updates the kept list.
  // A frame start empties the list first. A candidate must beat the
  // confidence floor strictly; then any kept entry strictly closer than the
  // squared distance makes it a duplicate, which wins over a full list.
  function automatic verdict_t judge_candidate(cand_t c);
    verdict_t v;
    logic     near;
    longint   dx;
    longint   dy;
    int       i;
    v.status = gds_pkg::STATUS_ACCEPT;
    v.x      = c.x;
    v.y      = c.y;
    v.z      = c.z;
    v.slot   = '0;
    near     = 1'b0;
    if (c.fs) roster_len = 0;
    if (c.conf <= conf_floor) begin
      v.status = gds_pkg::STATUS_LOWCONF;
    end else begin
      for (i = 0; i < roster_len && !near; i++) begin
        dx = longint'(c.x) - longint'(roster_x[i]);
        dy = longint'(c.y) - longint'(roster_y[i]);
        if (dx * dx + dy * dy < longint'({32'd0, clear_sq})) near = 1'b1;
      end
      if (near) begin
        v.status = gds_pkg::STATUS_DUP;
      end else if (roster_len >= KEEP_DEPTH) begin
        v.status = gds_pkg::STATUS_FULL;
      end else begin
        roster_x[roster_len] = c.x;
        roster_y[roster_len] = c.y;
        v.slot = gds_pkg::SLOT_W'(roster_len);
        roster_len++;
      end
    end
    by_status[v.status]++;
    return v;
  endfunction

  // Idle cycles before the next request on either side.
  function automatic int draw_wait(bit enabled);
    return enabled ? int'($urandom_range(0, 6)) : 0;
  endfunction

  // Request driver. A request is accepted at an edge where in_valid is high
  // and in_stall is low; its expected result is predicted right then, so the
  // prediction always sees the thresholds that the block uses. After each
  // acceptance a fresh gap is drawn; with no gap the next request follows on
  // the very next cycle and in_valid simply stays high.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        verdicts_due = {verdicts_due, judge_candidate(on_wire)};
        n_taken++;
        gap_left = draw_wait(send_idle);
      end
      // A stalled request stays on the wires untouched.
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cand_backlog.size() != 0) begin
          on_wire = cand_backlog.pop_front();
          in_valid    <= 1'b1;
          frame_start <= on_wire.fs;
          cand_x      <= on_wire.x;
          cand_y      <= on_wire.y;
          cand_z      <= on_wire.z;
          confidence  <= on_wire.conf;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string tag, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected 'h%h, got 'h%h", $time, tag, exp_v, got_v);
      errors++;
    end
  endtask

  // Result monitor. Each accepted result is matched against the oldest
  // expectation field by field. The receiver draws a stall for every result
  // and counts it down only while a result is actually waiting, so stalls
  // land on results rather than on empty cycles. The long hold from the
  // pressure process is merged in here so out_stall has a single driver.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got status %0d x %0d y %0d",
                   $time, status, out_x, out_y);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("status", 16'(want.status), 16'(status));
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_z", want.z, out_z);
          check_field("slot_index", 16'(want.slot), 16'(slot_index));
        end
        n_checked++;
        stall_left = draw_wait(recv_idle);
      end else if (out_valid && stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  // Pressure process: on a one-cycle request from the stimulus it keeps the
  // receiver stalled for a long stretch. The block parks one result, takes
  // one more candidate, and must then stall its input while the driver keeps
  // offering.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: no progress after %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, verdicts_due.size());
      $display("** greedy_distance_suppression_top: FAILED **");
      $finish;
    end
  end

  task automatic push_cand(input cand_t c);
    cand_backlog = {cand_backlog, c};
    n_offered++;
    if (c.fs) n_frames++;
  endtask

  task automatic add_cand(input logic fs, input int x, input int y, input int z,
                          input int conf);
    cand_t c;
    c.fs   = fs;
    c.x    = gds_pkg::COORD_W'(x);
    c.y    = gds_pkg::COORD_W'(y);
    c.z    = gds_pkg::COORD_W'(z);
    c.conf = gds_pkg::CONF_W'(conf);
    push_cand(c);
  endtask

  // Registers are only written while the block is idle. The predictor takes
  // the new value at once, since nothing is in flight.
  task automatic write_reg(input logic [gds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gds_pkg::DIST_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gds_pkg::REG_RADIUS_SQ) clear_sq = val;
    else conf_floor = val[gds_pkg::CONF_W-1:0];
    n_writes++;
  endtask

  // Waits until every queued request is accepted and every result checked.
  task automatic settle();
    @(negedge clk);
    while (n_taken != n_offered || verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One frame of candidates. Most frames are well formed: a frame start on
  // the first request and mostly confident candidates. Positions are a mix
  // of points close to an earlier one of the same frame (offsets around the
  // suppression radius, so both sides of the distance test are hit), the
  // corners of the coordinate range, and random points. A stray frame start
  // in the middle breaks a frame now and then.
  task automatic queue_frame(input int len, input int reach);
    cand_t                              c;
    logic signed [gds_pkg::COORD_W-1:0] seen_x [$];
    logic signed [gds_pkg::COORD_W-1:0] seen_y [$];
    int                                 k;
    int                                 j;
    int                                 pick;
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 19);
      c.fs = (k == 0) || (pick == 19);
      if (pick < 8 && seen_x.size() != 0) begin
        j = $urandom_range(0, seen_x.size() - 1);
        c.x = gds_pkg::COORD_W'(int'(seen_x[j]) + $urandom_range(0, 2 * reach + 4)
                                - (reach + 2));
        c.y = gds_pkg::COORD_W'(int'(seen_y[j]) + $urandom_range(0, 2 * reach + 4)
                                - (reach + 2));
      end else if (pick < 10) begin
        c.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        c.y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end else begin
        c.x = gds_pkg::COORD_W'($urandom);
        c.y = gds_pkg::COORD_W'($urandom);
      end
      c.z = gds_pkg::COORD_W'($urandom);
      if ($urandom_range(0, 9) < 7 && conf_floor != 8'hff) begin
        c.conf = gds_pkg::CONF_W'($urandom_range(int'(conf_floor) + 1, 255));
      end else begin
        c.conf = gds_pkg::CONF_W'($urandom);
      end
      seen_x = {seen_x, c.x};
      seen_y = {seen_y, c.y};
      push_cand(c);
    end
  endtask

  // One random phase under a single pair of thresholds. Frames are mostly
  // short; about one in six has 60 to 72 candidates, so the list can overflow.
  task automatic random_phase(input logic [gds_pkg::DIST_W-1:0] radius_v, input int reach,
                              input logic [gds_pkg::CONF_W-1:0] conf_v, input int count,
                              input bit s_idle, input bit r_idle, input bit squeeze);
    int made;
    int len;
    write_reg(gds_pkg::REG_RADIUS_SQ, radius_v);
    write_reg(gds_pkg::REG_CONF_MIN, gds_pkg::DIST_W'(conf_v));
    @(negedge clk);
    send_idle = s_idle;
    recv_idle = r_idle;
    made = 0;
    while (made < count) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 30);
      queue_frame(len, reach);
      made += len;
    end
    if (squeeze) begin
      hold_req = 1'b1;
      @(negedge clk);
      hold_req = 1'b0;
    end
    settle();
  endtask

  initial begin
    int reach_r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset thresholds: 0.8 m squared and a floor of 128. Confidence at and
    // below the floor, a near duplicate, the four corners of the range and a
    // point just outside the radius; then a frame start that clears the list
    // so the same point is stored again in slot zero.
    add_cand(1, 0, 0, 0, 0);
    add_cand(0, 0, 0, 0, 128);
    add_cand(0, 0, 0, -32768, 129);
    add_cand(0, 100, 100, 32767, 255);
    add_cand(0, -32768, -32768, 0, 200);
    add_cand(0, 32767, 32767, 1, 200);
    add_cand(0, 32767, -32768, -1, 200);
    add_cand(0, -32768, 32767, 7, 200);
    add_cand(0, 205, 0, 9, 200);
    add_cand(1, 205, 0, 3, 255);
    settle();

    // A distance exactly equal to the threshold is not a duplicate, one just
    // inside it is. With a floor of zero only zero confidence is rejected.
    write_reg(gds_pkg::REG_RADIUS_SQ, 32'd100);
    write_reg(gds_pkg::REG_CONF_MIN, 32'd0);
    @(negedge clk);
    add_cand(1, 10, -20, 5, 1);
    add_cand(0, 16, -12, 5, 1);
    add_cand(0, 16, -13, 5, 1);
    add_cand(0, 0, 0, 5, 0);
    add_cand(0, -32768, 0, 5, 255);
    settle();

    // A zero distance never suppresses, so the same point is stored twice.
    write_reg(gds_pkg::REG_RADIUS_SQ, 32'd0);
    write_reg(gds_pkg::REG_CONF_MIN, 32'd254);
    @(negedge clk);
    add_cand(1, 5, 5, 5, 255);
    add_cand(0, 5, 5, 6, 255);
    add_cand(0, 5, 5, 7, 254);
    settle();

    // The largest floor rejects everything.
    write_reg(gds_pkg::REG_RADIUS_SQ, 32'hffff_ffff);
    write_reg(gds_pkg::REG_CONF_MIN, 32'd255);
    @(negedge clk);
    add_cand(1, 0, 0, 0, 255);
    settle();

    // The largest distance: opposite corners still differ by more than it,
    // a full span along one axis does not.
    write_reg(gds_pkg::REG_CONF_MIN, 32'd100);
    @(negedge clk);
    add_cand(1, -32768, -32768, 0, 101);
    add_cand(0, 32767, 32767, 0, 101);
    add_cand(0, 32767, -32768, 0, 101);
    add_cand(0, 0, 0, 0, 101);
    settle();

    // Random phases, covering both extremes of each register, the reset
    // values, random values, and stretches where one or both sides never
    // idle. The long output hold falls in the second phase.
    random_phase(gds_pkg::RADIUS_SQ_RST, 205, gds_pkg::CONF_MIN_RST, 220, 1, 1, 0);
    random_phase(32'd0, 3, 8'd0, 220, 1, 0, 1);
    random_phase(32'd1, 1, 8'd200, 220, 0, 1, 0);
    random_phase(32'hffff_ffff, 65535, gds_pkg::CONF_MIN_RST, 200, 1, 1, 0);
    reach_r = $urandom_range(1, 3000);
    random_phase(gds_pkg::DIST_W'(reach_r * reach_r + $urandom_range(0, 2 * reach_r)),
                 reach_r, gds_pkg::CONF_W'($urandom_range(1, 254)), 220, 1, 1, 0);
    random_phase(32'd100, 10, 8'd255, 40, 1, 1, 0);
    reach_r = $urandom_range(1, 3000);
    random_phase(gds_pkg::DIST_W'(reach_r * reach_r), reach_r,
                 gds_pkg::CONF_W'($urandom_range(0, 255)), 220, 0, 0, 0);
    random_phase(gds_pkg::RADIUS_SQ_RST, 205, gds_pkg::CONF_MIN_RST, 240, 1, 1, 0);

    // Give a stray late result time to show up before judging the run.
    repeat (KEEP_DEPTH + 10) @(negedge clk);

    $display("Checked %0d results in %0d frames across %0d register writes.",
             n_checked, n_frames, n_writes);
    $display("Stored %0d, below floor %0d, near duplicates %0d, dropped on full list %0d.",
             by_status[gds_pkg::STATUS_ACCEPT], by_status[gds_pkg::STATUS_LOWCONF],
             by_status[gds_pkg::STATUS_DUP], by_status[gds_pkg::STATUS_FULL]);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("** greedy_distance_suppression_top: PASSED **");
    end else begin
      $display("** greedy_distance_suppression_top: FAILED **");
    end
    $finish;
  end

endmodule

/* greedy_distance_suppression_top.f */
hw/rtl/gds_pkg.sv
hw/rtl/gds_ctrl.sv
hw/rtl/gds_datapath.sv
hw/rtl/greedy_distance_suppression_top.sv
test/greedy_distance_suppression_top_tb.sv
